// ===== sv/hbdf_pkg.sv =====
// Shared types and constants for the bounded history dedup FIFO.
// Used by every module of the block but hbdf_ram; depends on nothing else.
package hbdf_pkg;

  // Default geometry of the history store
  localparam int HBDF_DEPTH       = 1024;
  localparam int HBDF_HANDLE_BITS = 32;

  // Fixed field widths of the item and result channels
  localparam int OP_W      = 2;
  localparam int HANDLE_W  = 32;
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 11;
  localparam int MAX_W     = 11;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 11'd1000;

  // Operation codes carried in tuser
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // One result item as handed from the core to the output register
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               index_error;
    logic               evicted;
    logic               stored;
    logic               found;
    logic [VALUE_W-1:0] read_value;
  } hbdf_result_t;

endpackage

// ===== sv/hbdf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependencies.
module hbdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hbdf_cfg.sv =====
// APB register file holding the max_entries limit.
// Depends on hbdf_pkg for address layout and reset value.
module hbdf_cfg
  import hbdf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [MAX_W-1:0]      max_entries_o
);

  logic [MAX_W-1:0] max_entries_q;
  logic             hit_max;

  // Decode the word address
  assign hit_max = (paddr[APB_ADDR_W-1:2] == REG_MAX_ENTRIES);

  // Take writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RESET;
    end else if (psel && penable && pwrite && hit_max) begin
      max_entries_q <= pwdata[MAX_W-1:0];
    end
  end

  // Return the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (hit_max) begin
      prdata = APB_DATA_W'(max_entries_q);
    end
  end

  assign pready        = 1'b1;
  assign max_entries_o = max_entries_q;

endmodule

// ===== sv/hbdf_core.sv =====
// Sequencer for the history: scans, reads and appends through the ring RAM.
// Depends on hbdf_pkg; drives one hbdf_ram instance held in the top level.
module hbdf_core
  import hbdf_pkg::*;
#(
  parameter int DEPTH       = HBDF_DEPTH,
  parameter int HANDLE_BITS = HBDF_HANDLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [MAX_W-1:0]         max_entries_i,
  // item side
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [HANDLE_W-1:0]      handle_i,
  input  logic                     fresh_i,
  input  logic [INDEX_W-1:0]       index_i,
  // result side
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output hbdf_result_t             res_o,
  // RAM side
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [HANDLE_BITS-1:0]   ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [HANDLE_BITS-1:0]   ram_rdata_i
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW + 1) > MAX_W) ? (CW + 1) : MAX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_READ,
    ST_RDWAIT,
    ST_POST
  } state_e;

  state_e                 state_q, state_d;
  logic [OP_W-1:0]        op_q, op_d;
  logic [HANDLE_BITS-1:0] h_q, h_d;
  logic [INDEX_W-1:0]     idx_q, idx_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          scan_q, scan_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic                   cmp_v_q, cmp_v_d;
  hbdf_result_t           res_q, res_d;

  logic [CMPW-1:0] lim;
  logic [CMPW-1:0] cnt_inc;
  logic            evict;
  logic            hit;
  logic            idx_err;
  logic [AW-1:0]   wr_pos;
  logic [AW-1:0]   rd_pos;
  logic [AW-1:0]   addr_next;
  logic [AW-1:0]   ptr_next;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] s);
    logic [AW:0] t;
    begin
      t = s;
      if (s >= (AW + 1)'(DEPTH)) begin
        t = s - (AW + 1)'(DEPTH);
      end
      ring_wrap = t[AW-1:0];
    end
  endfunction

  // Effective limit and the append decision
  assign lim     = (CMPW'(max_entries_i) > CMPW'(DEPTH)) ? CMPW'(DEPTH)
                                                         : CMPW'(max_entries_i);
  assign cnt_inc = CMPW'(cnt_q) + CMPW'(1);
  assign evict   = (cnt_inc > lim);

  // Ring positions for append and indexed read
  assign wr_pos  = ring_wrap((AW + 1)'(ptr_q) + (AW + 1)'(cnt_q));
  assign rd_pos  = ring_wrap((AW + 1)'(ptr_q) + (AW + 1)'(idx_q));
  assign idx_err = (CMPW'(idx_q) >= CMPW'(cnt_q)) || (CMPW'(idx_q) >= CMPW'(DEPTH));

  assign addr_next = (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);
  assign ptr_next  = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + AW'(1);

  // Compare the entry that came back from the last scan read
  assign hit = cmp_v_q && (ram_rdata_i == h_q);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    h_d      = h_q;
    idx_d    = idx_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    scan_d   = scan_q;
    addr_d   = addr_q;
    cmp_v_d  = 1'b0;
    res_d    = res_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = wr_pos;
    ram_wdata_o = h_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_i;
          h_d    = HANDLE_BITS'(handle_i);
          idx_d  = index_i;
          scan_d = '0;
          addr_d = ptr_q;
          res_d  = '0;
          res_d.count = COUNT_W'(cnt_q);
          case (op_i)
            OP_INSERT: state_d = fresh_i ? ST_SCAN : ST_COMMIT;
            OP_READ:   state_d = ST_READ;
            OP_LOOKUP: state_d = ST_SCAN;
            default:   state_d = ST_POST;
          endcase
        end
      end

      // Issue one read per cycle, compare each entry in the cycle after its read
      ST_SCAN: begin
        if (hit || (scan_q >= cnt_q)) begin
          if ((op_q == OP_INSERT) && !hit) begin
            state_d = ST_COMMIT;
          end else begin
            res_d.found = hit;
            state_d     = ST_POST;
          end
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = addr_q;
          addr_d      = addr_next;
          scan_d      = scan_q + CW'(1);
          cmp_v_d     = 1'b1;
        end
      end

      // Append at the young end, drop the oldest past the limit
      ST_COMMIT: begin
        ram_we_o      = 1'b1;
        res_d.stored  = 1'b1;
        res_d.evicted = evict;
        if (evict) begin
          ptr_d = ptr_next;
        end else begin
          cnt_d = CW'(cnt_inc);
        end
        res_d.count = COUNT_W'(evict ? cnt_q : CW'(cnt_inc));
        state_d     = ST_POST;
      end

      ST_READ: begin
        if (idx_err) begin
          res_d.index_error = 1'b1;
          state_d           = ST_POST;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = rd_pos;
          state_d     = ST_RDWAIT;
        end
      end

      ST_RDWAIT: begin
        res_d.read_value = VALUE_W'(ram_rdata_i);
        state_d          = ST_POST;
      end

      // Hold the result until the output register takes it
      ST_POST: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_INSERT;
      h_q     <= '0;
      idx_q   <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
      scan_q  <= '0;
      addr_q  <= '0;
      cmp_v_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      h_q     <= h_d;
      idx_q   <= idx_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      addr_q  <= addr_d;
      cmp_v_q <= cmp_v_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_POST);
  assign res_o       = res_q;

endmodule

// ===== sv/hbdf_outreg.sv =====
// Output register for result items; frees the core while a result waits.
// Depends on hbdf_pkg for the result struct and output width.
module hbdf_outreg
  import hbdf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  output logic                  res_ready_o,
  input  hbdf_result_t          res_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic         valid_q;
  hbdf_result_t data_q;

  assign res_ready_o = !valid_q || m_axis_tready;

  // Load a new result or drain the held one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else if (res_valid_i && res_ready_o) begin
      valid_q <= 1'b1;
      data_q  <= res_i;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(data_q);

endmodule

// ===== sv/bounded_history_dedup_fifo.sv =====
// Top level of the bounded history dedup FIFO.
// Depends on hbdf_pkg, hbdf_cfg, hbdf_ram, hbdf_core and hbdf_outreg.
//
//  port group  | dir | contents
//  ------------+-----+------------------------------------------------
//  s_axis_*    | in  | item: op in tuser, handle/fresh/index in tdata
//  m_axis_*    | out | result: value, flags and count in tdata
//  APB         | in  | max_entries at byte address 0
//
// An unused op code goes straight to its result, an insert without fresh appends, and
// a read reads the RAM only when its index is in range. Lookup and fresh insert scan one
// RAM read per cycle from the oldest entry through the single read port of the history
// RAM; a miss scans the whole count, a hit ends sooner. A result waiting in the output
// register does not block the next item; a second waiting result holds the core.
// Reset empties the history at once, no clearing pass: entries beyond the count are never read.
module bounded_history_dedup_fifo
  import hbdf_pkg::*;
#(
  parameter int DEPTH       = HBDF_DEPTH,
  parameter int HANDLE_BITS = HBDF_HANDLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // handle[31:0], fresh[32], index[42:33]
  input  logic [OP_W-1:0]       s_axis_tuser,  // op[1:0]
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_value[31:0], found[32],
                                               // stored[33], evicted[34],
                                               // index_error[35], count[46:36]
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(DEPTH);

  logic [MAX_W-1:0]       max_entries;
  logic                   res_valid;
  logic                   res_ready;
  hbdf_result_t           res;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [HANDLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [HANDLE_BITS-1:0] ram_rdata;

  // Limit register
  hbdf_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_entries_o (max_entries)
  );

  // History ring store
  hbdf_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  hbdf_core #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_entries_i (max_entries),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser),
    .handle_i      (s_axis_tdata[HANDLE_W-1:0]),
    .fresh_i       (s_axis_tdata[HANDLE_W]),
    .index_i       (s_axis_tdata[HANDLE_W+INDEX_W:HANDLE_W+1]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  // Result output register
  hbdf_outreg u_outreg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_ready_o   (res_ready),
    .res_i         (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
